// ===== rtl/bpd_pkg.sv =====
package bpd_pkg;

	// sizing
	localparam int NUM_BUTTONS   = 6;
	localparam int QUEUE_DEPTH   = 16;
	localparam int TABLE_BUTTONS = 6;
	localparam int ACT_W         = 5;
	localparam int CNT_OUT_W     = 5;
	localparam int LANE_W        = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int NUM_SLOTS     = 2 * NUM_BUTTONS;
	localparam int SLOT_W        = $clog2(NUM_SLOTS);
	localparam int QIDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int S_DATA_W      = ((NUM_BUTTONS + 32 + 7) / 8) * 8;
	localparam int M_DATA_W      = ((ACT_W + CNT_OUT_W + 7) / 8) * 8;
	localparam int ADDR_W        = 4;

	// register reset values
	localparam logic [31:0] MEDIUM_RST = 32'd1000;
	localparam logic [31:0] LONG_RST   = 32'd3000;
	localparam logic [4:0]  LIMIT_RST  = 5'd16;

	// action codes
	typedef enum logic [ACT_W-1:0] {
		ACT_NOTHING,
		ACT_VOL_SPK_DOWN,
		ACT_VOL_SPK_UP,
		ACT_PTT_NET,
		ACT_PTT_NET_LOW,
		ACT_PTT_NET_MEDIUM,
		ACT_VOL_MIC_DOWN,
		ACT_VOL_MIC_UP,
		ACT_AUDIO_RETURN,
		ACT_SAVE_STATE,
		ACT_PTT_NET_RELEASE,
		ACT_FUNCTION1,
		ACT_FUNCTION2,
		ACT_FUNCTION3,
		ACT_FUNCTION4,
		ACT_FUNCTION5,
		ACT_FUNCTION6,
		ACT_CLICK,
		ACT_NOTIFY_MEDIUM
	} act_t;

	typedef enum logic [1:0] {
		KIND_SHORT,
		KIND_MEDIUM,
		KIND_LONG,
		KIND_RELEASE
	} kind_t;

	typedef enum logic {
		OP_POLL,
		OP_FETCH
	} op_t;

	typedef enum logic [1:0] {
		REG_MEDIUM,
		REG_LONG,
		REG_TEST_MODE,
		REG_QUEUE_LIMIT
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_DONE
	} state_t;

	// two codes one lane can raise per poll, in queue order
	typedef struct packed {
		act_t first;
		act_t second;
	} lane_res_t;

	// queue control from the sequencer
	typedef struct packed {
		logic push;
		act_t code;
		logic pop;
	} fifo_ctl_t;

	// action tables, [mode][kind][button]
	localparam act_t ACT_TABLE [2][4][TABLE_BUTTONS] = '{
		'{
			'{ACT_VOL_SPK_DOWN, ACT_VOL_SPK_UP, ACT_PTT_NET, ACT_PTT_NET_LOW,
			  ACT_PTT_NET, ACT_PTT_NET_MEDIUM},
			'{ACT_VOL_MIC_DOWN, ACT_VOL_MIC_UP, ACT_NOTHING, ACT_NOTHING,
			  ACT_NOTHING, ACT_NOTHING},
			'{ACT_AUDIO_RETURN, ACT_SAVE_STATE, ACT_NOTHING, ACT_NOTHING,
			  ACT_NOTHING, ACT_NOTHING},
			'{ACT_NOTHING, ACT_NOTHING, ACT_PTT_NET_RELEASE, ACT_PTT_NET_RELEASE,
			  ACT_PTT_NET_RELEASE, ACT_PTT_NET_RELEASE}
		},
		'{
			'{ACT_FUNCTION1, ACT_FUNCTION2, ACT_FUNCTION3, ACT_FUNCTION4,
			  ACT_FUNCTION5, ACT_FUNCTION6},
			'{ACT_NOTHING, ACT_NOTHING, ACT_NOTHING, ACT_NOTHING,
			  ACT_NOTHING, ACT_NOTHING},
			'{ACT_NOTHING, ACT_NOTHING, ACT_NOTHING, ACT_NOTHING,
			  ACT_NOTHING, ACT_NOTHING},
			'{ACT_CLICK, ACT_CLICK, ACT_CLICK, ACT_CLICK,
			  ACT_CLICK, ACT_CLICK}
		}
	};

	// buttons past the table raise nothing
	function automatic act_t act_lookup(input logic mode, input kind_t kind,
			input logic [LANE_W-1:0] button);
		act_t code;
		code = ACT_NOTHING;
		if (32'(button) < TABLE_BUTTONS) begin
			code = ACT_TABLE[mode][kind][3'(button)];
		end
		return code;
	endfunction

endpackage

// ===== rtl/bpd_lane.sv =====
module bpd_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bpd_pkg::LANE_W-1:0] idx,
	input  logic                      start,
	input  logic                      key,
	input  logic [31:0]               now,
	input  logic [31:0]               medium_ms,
	input  logic [31:0]               long_ms,
	input  logic                      test_mode,
	output bpd_pkg::lane_res_t        res
);
	import bpd_pkg::*;

	logic [31:0] press_start_q;
	logic        held_q, short_q, medium_q, long_q, handled_q;
	lane_res_t   res_q;

	act_t        s_code, m_code, l_code, r_code;
	logic [31:0] held_time;
	logic        held_n, short_n, medium_n, long_n, handled_n;
	logic        load_start;
	lane_res_t   res_n;

	// table codes of this button
	assign s_code    = act_lookup(test_mode, KIND_SHORT, idx);
	assign m_code    = act_lookup(test_mode, KIND_MEDIUM, idx);
	assign l_code    = act_lookup(test_mode, KIND_LONG, idx);
	assign r_code    = act_lookup(test_mode, KIND_RELEASE, idx);
	assign held_time = now - press_start_q;

	// classify the press and pick the codes to queue
	always_comb begin
		held_n     = held_q;
		short_n    = short_q;
		medium_n   = medium_q;
		long_n     = long_q;
		handled_n  = handled_q;
		load_start = 1'b0;
		res_n      = '{first: ACT_NOTHING, second: ACT_NOTHING};
		if (held_q && key) begin
			if (held_time > long_ms && l_code != ACT_NOTHING) begin
				if (!long_q) begin
					long_n = 1'b1;
					if (!handled_q) begin
						handled_n   = 1'b1;
						res_n.first = l_code;
					end
				end
			end else if (held_time > medium_ms && m_code != ACT_NOTHING) begin
				if (!medium_q) begin
					medium_n = 1'b1;
					if (l_code != ACT_NOTHING) begin
						res_n.first = ACT_NOTIFY_MEDIUM;
					end else if (!handled_q) begin
						handled_n   = 1'b1;
						res_n.first = m_code;
					end
				end
			end else if (s_code != ACT_NOTHING && !short_q) begin
				short_n = 1'b1;
				if (!handled_q && m_code == ACT_NOTHING && l_code == ACT_NOTHING) begin
					handled_n   = 1'b1;
					res_n.first = s_code;
				end
			end
		end
		// new press
		if (!held_q && key) begin
			load_start = 1'b1;
			held_n     = 1'b1;
		end
		// release
		if (held_q && !key) begin
			if (!handled_q) begin
				if (long_q) begin
					res_n.first = l_code;
				end else if (medium_q) begin
					res_n.first = m_code;
				end else if (short_q) begin
					res_n.first = s_code;
				end
			end
			res_n.second = r_code;
			short_n      = 1'b0;
			medium_n     = 1'b0;
			long_n       = 1'b0;
			handled_n    = 1'b0;
			held_n       = 1'b0;
		end
	end

	// press state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= 1'b0;
			short_q   <= 1'b0;
			medium_q  <= 1'b0;
			long_q    <= 1'b0;
			handled_q <= 1'b0;
		end else if (start) begin
			held_q    <= held_n;
			short_q   <= short_n;
			medium_q  <= medium_n;
			long_q    <= long_n;
			handled_q <= handled_n;
		end
	end

	// press time and found codes
	always_ff @(posedge clk) begin
		if (start) begin
			res_q <= res_n;
			if (load_start) begin
				press_start_q <= now;
			end
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/bpd_fifo.sv =====
module bpd_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpd_pkg::fifo_ctl_t         ctl,
	input  logic [4:0]                 queue_limit,
	output logic [bpd_pkg::QCNT_W-1:0] count,
	output bpd_pkg::act_t              rd_data
);
	import bpd_pkg::*;

	act_t              mem [QUEUE_DEPTH];
	act_t              rd_q;
	logic [QIDX_W-1:0] head_q;
	logic [QCNT_W-1:0] count_q;

	logic              full, do_push, do_pop;
	logic [QCNT_W:0]   wr_sum;
	logic [QIDX_W-1:0] wr_addr, head_inc;
	int unsigned       eff_limit;

	// limit above depth acts as depth
	assign eff_limit = (32'(queue_limit) > QUEUE_DEPTH) ? QUEUE_DEPTH : 32'(queue_limit);
	assign full      = 32'(count_q) >= eff_limit;
	assign do_push   = ctl.push && ctl.code != ACT_NOTHING && !full;
	assign do_pop    = ctl.pop && count_q != '0;

	// tail address with wrap
	assign wr_sum   = (QCNT_W+1)'(head_q) + (QCNT_W+1)'(count_q);
	assign wr_addr  = (wr_sum >= (QCNT_W+1)'(QUEUE_DEPTH)) ?
		QIDX_W'(wr_sum - (QCNT_W+1)'(QUEUE_DEPTH)) : QIDX_W'(wr_sum);
	assign head_inc = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (do_push) begin
			count_q <= count_q + 1'b1;
		end else if (do_pop) begin
			head_q  <= head_inc;
			count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_addr] <= ctl.code;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			rd_q <= mem[head_q];
		end
	end

	assign count   = count_q;
	assign rd_data = rd_q;

endmodule

// ===== rtl/button_press_duration_classifier_unit.sv =====
// channel  dir  tvalid/tready  payload
// s        in   s_tvalid       s_tuser opcode, s_tdata keys/time_ms
// m        out  m_tvalid       m_tdata action/queue_count
// apb      in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// a poll registers the lane results, then pushes one action per cycle that its
// buttons raise (at most two per button), set by the single write port of the
// action queue; a fetch reads the queue head through a registered queue read
// a new word is taken while the last result still waits in the output register
// reset is asynchronous active low and clears the press flags (not the press start time) and the queue
module button_press_duration_classifier_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// keys [NUM_BUTTONS-1:0], time_ms [NUM_BUTTONS+31:NUM_BUTTONS]
	input  logic [bpd_pkg::S_DATA_W-1:0] s_tdata,
	// opcode [0]
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// action [4:0], queue_count [9:5]
	output logic [bpd_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bpd_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import bpd_pkg::*;

	logic [31:0] medium_q, long_q;
	logic        test_mode_q;
	logic [4:0]  limit_q;

	state_t      state_q, state_n;
	logic [NUM_SLOTS-1:0] done_q, valid_slots, pending;
	logic        fetch_hit_q;
	logic        out_valid_q;
	act_t        out_action_q;
	logic [CNT_OUT_W-1:0] out_count_q;

	logic        accept, poll_start, out_free, out_load, cfg_wr;
	logic [SLOT_W-1:0] sel;
	lane_res_t   lane_res [NUM_BUTTONS];
	act_t        slot [NUM_SLOTS];
	fifo_ctl_t   fifo_ctl;
	logic [QCNT_W-1:0] fifo_count;
	act_t        fifo_rd;
	reg_idx_t    reg_idx;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			medium_q    <= MEDIUM_RST;
			long_q      <= LONG_RST;
			test_mode_q <= 1'b0;
			limit_q     <= LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MEDIUM:      medium_q    <= pwdata;
				REG_LONG:        long_q      <= pwdata;
				REG_TEST_MODE:   test_mode_q <= pwdata[0];
				REG_QUEUE_LIMIT: limit_q     <= pwdata[4:0];
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_MEDIUM:      prdata = medium_q;
			REG_LONG:        prdata = long_q;
			REG_TEST_MODE:   prdata = {31'd0, test_mode_q};
			REG_QUEUE_LIMIT: prdata = {27'd0, limit_q};
		endcase
	end

	assign accept     = s_tvalid && s_tready;
	assign poll_start = accept && op_t'(s_tuser) == OP_POLL;
	assign out_free   = !out_valid_q || m_tready;

	// one lane per button
	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		bpd_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (LANE_W'(g)),
			.start     (poll_start),
			.key       (s_tdata[g]),
			.now       (s_tdata[NUM_BUTTONS+31:NUM_BUTTONS]),
			.medium_ms (medium_q),
			.long_ms   (long_q),
			.test_mode (test_mode_q),
			.res       (lane_res[g])
		);
		assign slot[2*g]            = lane_res[g].first;
		assign slot[2*g+1]          = lane_res[g].second;
		assign valid_slots[2*g]     = lane_res[g].first != ACT_NOTHING;
		assign valid_slots[2*g+1]   = lane_res[g].second != ACT_NOTHING;
	end

	// merge: lowest pending slot goes next, keeping button order
	assign pending = valid_slots & ~done_q;

	always_comb begin
		sel = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (pending[i]) begin
				sel = SLOT_W'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_n = (op_t'(s_tuser) == OP_POLL) ? ST_PUSH : ST_DONE;
				end
			end
			ST_PUSH: begin
				if (pending == '0) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready      = state_q == ST_IDLE;
		out_load      = state_q == ST_DONE && out_free;
		fifo_ctl.push = state_q == ST_PUSH && pending != '0;
		fifo_ctl.code = slot[sel];
		fifo_ctl.pop  = accept && op_t'(s_tuser) == OP_FETCH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// slot bookkeeping and fetch flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			fetch_hit_q <= 1'b0;
		end else if (accept) begin
			done_q      <= '0;
			fetch_hit_q <= op_t'(s_tuser) == OP_FETCH && fifo_count != '0;
		end else if (fifo_ctl.push) begin
			done_q[sel] <= 1'b1;
		end
	end

	bpd_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (fifo_ctl),
		.queue_limit (limit_q),
		.count       (fifo_count),
		.rd_data     (fifo_rd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_action_q <= fetch_hit_q ? fifo_rd : ACT_NOTHING;
			out_count_q  <= CNT_OUT_W'(fifo_count);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'({out_count_q, out_action_q});

endmodule

// ===== rtl/bpd_checker.sv =====
module bpd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [bpd_pkg::S_DATA_W-1:0] s_tdata,
	input logic                         s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [bpd_pkg::M_DATA_W-1:0] m_tdata,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [bpd_pkg::ADDR_W-1:0]   paddr,
	input logic [31:0]                  pwdata,
	input logic [31:0]                  prdata,
	input logic                         pready
);
	import bpd_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// one word at a time: input closes right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted while busy");

	// no result during reset
	a_reset_out: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// a medium threshold write reads back at the same address
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[3:2] == REG_MEDIUM)
		##1 (paddr == $past(paddr)) |-> prdata == $past(pwdata))
		else $error("medium threshold readback mismatch");

	// a waiting input word holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input word changed while waiting");

endmodule

bind button_press_duration_classifier_unit bpd_checker u_bpd_checker (.*);
